FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms, reset-qualified
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked at every rising clk edge outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hdl/sakl_pkg.sv
// ----------------------------------------------------------------------------
// sakl_pkg
// types and constants of the slot allocator with key lookup
// ----------------------------------------------------------------------------
package sakl_pkg;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	localparam int NUM_SLOTS = 64;
	localparam int ADDR_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

	localparam int KEY_W  = 64;
	localparam int KIND_W = 3;
	localparam int SLOT_W = 6;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;
	localparam int CFG_W  = 7;
	localparam int CMP_W  = imax(imax(CFG_W, CNT_W), SLOT_W + 1);

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_LOOKUP = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_MISS  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] idx;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot_number;
		logic [KIND_W-1:0] found_kind;
	} res_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [KEY_W-1:0]  wr_key;
		logic [KIND_W-1:0] wr_kind;
		logic              clr_en;
		logic [ADDR_W-1:0] clr_addr;
	} store_req_t;

	typedef struct packed {
		logic              busy;
		logic [KEY_W-1:0]  key;
		logic [KIND_W-1:0] kind;
	} store_rd_t;

endpackage

FILE: hdl/slot_allocator_with_key_lookup_unit.sv
// ----------------------------------------------------------------------------
// slot_allocator_with_key_lookup_unit
// first-fit slot allocator with associative key lookup over a fixed table
// ----------------------------------------------------------------------------
// One word is taken at a time. A free or an unknown operation is settled
// without reading the table. Allocate and lookup walk the slots from slot 0
// upward through one memory read port and one 64-bit key comparator, one slot
// a cycle, and stop at the first slot that answers; a miss walks every slot
// of the count. The next word is taken the cycle after the result moves into
// the output register, even while that result still waits on m_tready.
// The table comes out of reset empty, with no clearing pass.
module slot_allocator_with_key_lookup_unit import sakl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_wdata,  // slots_in_use
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,    // origin_address, hook_kind, slot_index
	input  logic [OP_W-1:0]       s_tuser,    // operation
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,    // slot_number, found_kind
	output logic [STAT_W-1:0]     m_tuser     // status
);

	logic [CFG_W-1:0] cfg_q;
	logic [CNT_W-1:0] cnt;
	item_t            in_item;
	logic             in_accept;
	store_req_t       req;
	store_rd_t        rd;
	logic             res_valid;
	res_t             res;
	logic             res_take;
	logic             m_tvalid_q;
	res_t             out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// saturate the slot count to the table size
	assign cnt = (CMP_W'(cfg_q) > CMP_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : CNT_W'(cfg_q);

	assign in_accept    = s_tvalid && s_tready;
	assign in_item.op   = op_t'(s_tuser);
	assign in_item.key  = s_tdata[KEY_W-1:0];
	assign in_item.kind = s_tdata[KEY_W +: KIND_W];
	assign in_item.idx  = s_tdata[KEY_W + KIND_W +: SLOT_W];

	sakl_slot_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rd     (rd)
	);

	sakl_scan_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_item   (in_item),
		.cnt       (cnt),
		.ready     (s_tready),
		.req       (req),
		.rd        (rd),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	assign res_take = res_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {{(OUT_DATA_W - SLOT_W - KIND_W){1'b0}}, out_q.found_kind,
	                   out_q.slot_number};

`include "assert_macros.svh"

	`ASSERT_IMPL(a_busy_after_accept, in_accept, ##1 !s_tready, "ready high after accept")
	`ASSERT_IMPL(a_miss_zero, m_tvalid && (m_tuser != ST_OK),
		(m_tdata[SLOT_W + KIND_W - 1:0] == '0), "nonzero fields on failed word")
	`ASSERT_CLK(a_result_from_work, $rose(m_tvalid) |-> $past(!s_tready),
		"result word without a pending item")

endmodule

FILE: hdl/sakl_slot_store.sv
// ----------------------------------------------------------------------------
// sakl_slot_store
// slot table: busy flags in flops, key and kind memories, registered read
// ----------------------------------------------------------------------------
module sakl_slot_store import sakl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  store_req_t req,
	output store_rd_t  rd
);

	logic [NUM_SLOTS-1:0] busy_q;
	logic [KEY_W-1:0]     key_mem  [NUM_SLOTS];
	logic [KIND_W-1:0]    kind_mem [NUM_SLOTS];
	logic                 rd_busy_q;
	logic [KEY_W-1:0]     rd_key_q;
	logic [KIND_W-1:0]    rd_kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			if (req.wr_en) begin
				busy_q[req.wr_addr] <= 1'b1;
			end
			if (req.clr_en) begin
				busy_q[req.clr_addr] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			key_mem[req.wr_addr]  <= req.wr_key;
			kind_mem[req.wr_addr] <= req.wr_kind;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_busy_q <= busy_q[req.rd_addr];
			rd_key_q  <= key_mem[req.rd_addr];
			rd_kind_q <= kind_mem[req.rd_addr];
		end
	end

	assign rd.busy = rd_busy_q;
	assign rd.key  = rd_key_q;
	assign rd.kind = rd_kind_q;

endmodule

FILE: hdl/sakl_scan_ctrl.sv
// ----------------------------------------------------------------------------
// sakl_scan_ctrl
// sequencer that walks the slots one a cycle through a single key comparator
// ----------------------------------------------------------------------------
module sakl_scan_ctrl import sakl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_accept,
	input  item_t            in_item,
	input  logic [CNT_W-1:0] cnt,
	output logic             ready,
	output store_req_t       req,
	input  store_rd_t        rd,
	output logic             res_valid,
	output res_t             res,
	input  logic             res_take
);

	state_t            state_q, state_d;
	item_t             item_q;
	logic [CNT_W-1:0]  ptr_q;
	logic              vld_s1;
	logic [ADDR_W-1:0] idx_s1;
	res_t              res_q, res_d;

	logic              hit;
	logic              last;
	logic              in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign last     = (CNT_W'(idx_s1) + CNT_W'(1)) == cnt;
	assign in_range = CMP_W'(item_q.idx) < CMP_W'(cnt);
	assign hit      = (item_q.op == OP_ALLOC) ? !rd.busy
	                                          : (rd.busy && (rd.key == item_q.key));

	always_comb begin
		state_d   = state_q;
		res_d     = res_q;
		ready     = 1'b0;
		res_valid = 1'b0;
		req       = '0;
		req.rd_addr  = ptr_q[ADDR_W-1:0];
		req.wr_addr  = idx_s1;
		req.wr_key   = item_q.key;
		req.wr_kind  = item_q.kind;
		req.clr_addr = ADDR_W'(item_q.idx);
		case (state_q)
			S_IDLE: begin
				ready = 1'b1;
				if (in_accept) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				case (item_q.op)
					OP_FREE: begin
						if (in_range) begin
							req.clr_en = 1'b1;
							res_d = '{ST_OK, item_q.idx, '0};
						end else begin
							res_d = '{ST_RANGE, '0, '0};
						end
						state_d = S_DONE;
					end
					OP_ALLOC, OP_LOOKUP: begin
						req.rd_en = ptr_q < cnt;
						if (vld_s1 && hit) begin
							req.wr_en = item_q.op == OP_ALLOC;
							res_d = '{ST_OK, SLOT_W'(idx_s1),
								(item_q.op == OP_LOOKUP) ? rd.kind : KIND_W'(0)};
							state_d = S_DONE;
						end else if ((vld_s1 && last) || (cnt == '0)) begin
							res_d = '{ST_MISS, '0, '0};
							state_d = S_DONE;
						end
					end
					default: begin
						res_d = '{ST_MISS, '0, '0};
						state_d = S_DONE;
					end
				endcase
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req.rd_en;
			if (state_q == S_IDLE) begin
				ptr_q <= '0;
			end else if (req.rd_en) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q[ADDR_W-1:0];
		res_q  <= res_d;
		if (in_accept && (state_q == S_IDLE)) begin
			item_q <= in_item;
		end
	end

	assign res = res_q;

endmodule

FILE: dv/slot_reply_checker.sv
// ----------------------------------------------------------------------------
// slot_reply_checker
// watches both streams and the config port of the slot allocator, keeps its
// own copy of the slot table, predicts each reply and compares it field by
// field in order of arrival
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slot_reply_checker import sakl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,    // origin_address, hook_kind, slot_index
	input  logic [OP_W-1:0]       s_tuser,    // operation
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,    // slot_number, found_kind
	input  logic [STAT_W-1:0]     m_tuser,    // status
	output int                    mismatches,
	output int                    outstanding,
	output int                    checked,
	output int                    lookup_hits,
	output int                    alloc_full
);

	logic              slot_taken [NUM_SLOTS];
	logic [KEY_W-1:0]  slot_addr  [NUM_SLOTS];
	logic [KIND_W-1:0] slot_code  [NUM_SLOTS];
	logic [CFG_W-1:0]  slot_limit;

	res_t  expected_replies[$];
	item_t word_in;
	res_t  want;
	res_t  got;

	function automatic res_t predict_slot_op(input item_t w);
		res_t r;
		int   n;
		bit   hit;
		r.status      = ST_MISS;
		r.slot_number = '0;
		r.found_kind  = '0;
		hit           = 1'b0;
		n = (int'(slot_limit) > NUM_SLOTS) ? NUM_SLOTS : int'(slot_limit);
		case (w.op)
			OP_ALLOC: begin
				for (int i = 0; i < n; i++) begin
					if (!hit && !slot_taken[i]) begin
						hit           = 1'b1;
						slot_taken[i] = 1'b1;
						slot_addr[i]  = w.key;
						slot_code[i]  = w.kind;
						r.status      = ST_OK;
						r.slot_number = SLOT_W'(i);
					end
				end
			end
			OP_FREE: begin
				if (int'(w.idx) < n) begin
					slot_taken[w.idx] = 1'b0;
					r.status          = ST_OK;
					r.slot_number     = w.idx;
				end else begin
					r.status = ST_RANGE;
				end
			end
			OP_LOOKUP: begin
				for (int i = 0; i < n; i++) begin
					if (!hit && slot_taken[i] && slot_addr[i] == w.key) begin
						hit           = 1'b1;
						r.status      = ST_OK;
						r.slot_number = SLOT_W'(i);
						r.found_kind  = slot_code[i];
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic flag_field(input string field, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		mismatches++;
		$display("%0t %s mismatch: expected %0d, actual %0d", $time, field,
			exp_v, act_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_taken[i] = 1'b0;
				slot_addr[i]  = '0;
				slot_code[i]  = '0;
			end
			slot_limit = CFG_RESET;
			expected_replies.delete();
			mismatches  = 0;
			outstanding = 0;
			checked     = 0;
			lookup_hits = 0;
			alloc_full  = 0;
		end else begin
			if (cfg_we)
				slot_limit = cfg_wdata;
			if (m_tvalid && m_tready) begin
				got.status      = status_t'(m_tuser);
				got.slot_number = m_tdata[SLOT_W-1:0];
				got.found_kind  = m_tdata[SLOT_W +: KIND_W];
				if (expected_replies.size() == 0) begin
					mismatches++;
					$display("%0t unexpected reply: status %0d slot %0d kind %0d", $time,
						got.status, got.slot_number, got.found_kind);
				end else begin
					want = expected_replies.pop_front();
					checked++;
					if (got.status !== want.status)
						flag_field("status", want.status, got.status);
					if (got.slot_number !== want.slot_number)
						flag_field("slot_number", want.slot_number, got.slot_number);
					if (got.found_kind !== want.found_kind)
						flag_field("found_kind", want.found_kind, got.found_kind);
				end
			end
			if (s_tvalid && s_tready) begin
				word_in.op   = op_t'(s_tuser);
				word_in.key  = s_tdata[KEY_W-1:0];
				word_in.kind = s_tdata[KEY_W +: KIND_W];
				word_in.idx  = s_tdata[KEY_W+KIND_W +: SLOT_W];
				want = predict_slot_op(word_in);
				if (word_in.op == OP_LOOKUP && want.status == ST_OK)
					lookup_hits++;
				if (word_in.op == OP_ALLOC && want.status == ST_MISS)
					alloc_full++;
				expected_replies.push_back(want);
			end
			outstanding = expected_replies.size();
		end
	end

endmodule

FILE: dv/slot_allocator_with_key_lookup_unit_test.sv
// ----------------------------------------------------------------------------
// slot_allocator_with_key_lookup_unit_test
// drives allocate, free, lookup and unused-code words into the slot allocator
// under a series of slot-count settings, with random gaps on both streams;
// the checker beside the block predicts and compares every reply
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slot_allocator_with_key_lookup_unit_test import sakl_pkg::*;;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_WORDS = 48;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [OP_W-1:0]       s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]     m_tuser;

	int mismatches;
	int outstanding;
	int checked;
	int lookup_hits;
	int alloc_full;

	bit               quiet = 1'b0;
	int               stall_cycles = 0;
	int               words_by_op[4] = '{0, 0, 0, 0};
	int               settings_run = 1;
	logic [KEY_W-1:0] key_pool[8];
	int               count_plan[10];

	always #5 clk = ~clk;

	slot_allocator_with_key_lookup_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	slot_reply_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked),
		.lookup_hits (lookup_hits),
		.alloc_full  (alloc_full)
	);

	always @(negedge clk)
		m_tready <= quiet || ($urandom_range(0, 99) >= 12);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t no handshake for %0d cycles", $time, stall_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic push_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] idx);
		while (!quiet && $urandom_range(0, 99) < 12) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata  <= {{(IN_DATA_W-KEY_W-KIND_W-SLOT_W){1'b0}}, idx, kind, key};
		s_tuser  <= op;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		words_by_op[op]++;
		@(negedge clk);
	endtask

	task automatic wait_for_replies();
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	task automatic set_slot_count(input logic [CFG_W-1:0] count);
		wait_for_replies();
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= count;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	task automatic send_random_word(input int alloc_pct, input int count);
		int               pick;
		int               top_idx;
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic [SLOT_W-1:0] idx;
		pick = $urandom_range(0, 99);
		if (pick < alloc_pct)
			op = OP_ALLOC;
		else if (pick < 70)
			op = OP_FREE;
		else if (pick < 95)
			op = OP_LOOKUP;
		else
			op = OP_UNUSED;
		pick = $urandom_range(0, 9);
		key = (pick < 8) ? key_pool[pick] : {$urandom, $urandom};
		// mostly indices near the usable range, sometimes anywhere
		top_idx = (count >= 63) ? 63 : count + 1;
		if ($urandom_range(0, 3) == 0)
			idx = SLOT_W'($urandom_range(0, 63));
		else
			idx = SLOT_W'($urandom_range(0, top_idx));
		push_word(op, key, KIND_W'($urandom_range(0, 7)), idx);
	endtask

	initial begin
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			key_pool[i] = {$urandom, $urandom};
		count_plan = '{64, 1, 127, 8, 3, 64, 16, 2, 63, 0};
		count_plan[9] = $urandom_range(0, 127);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// full table after reset: duplicates, misses, frees of busy and idle slots, unused code
		push_word(OP_ALLOC, '0, 3'd0, 6'd0);
		push_word(OP_ALLOC, '1, 3'd7, 6'd63);
		push_word(OP_ALLOC, '1, 3'd3, 6'd0);
		push_word(OP_LOOKUP, '1, 3'd0, 6'd0);
		push_word(OP_LOOKUP, '0, 3'd7, 6'd63);
		push_word(OP_LOOKUP, 64'h5555_5555_5555_5555, 3'd0, 6'd0);
		push_word(OP_FREE, '0, 3'd0, 6'd1);
		push_word(OP_LOOKUP, '1, 3'd0, 6'd0);
		push_word(OP_FREE, '1, 3'd7, 6'd63);
		push_word(OP_UNUSED, '1, 3'd7, 6'd63);
		push_word(OP_ALLOC, 64'hAAAA_AAAA_AAAA_AAAA, 3'd5, 6'd0);

		// zero slots usable
		set_slot_count(7'd0);
		push_word(OP_ALLOC, '1, 3'd7, 6'd0);
		push_word(OP_LOOKUP, '0, 3'd0, 6'd0);
		push_word(OP_FREE, '0, 3'd0, 6'd0);

		// reduced count hides busy slots above it
		set_slot_count(7'd2);
		push_word(OP_ALLOC, '0, 3'd2, 6'd0);
		push_word(OP_FREE, '0, 3'd0, 6'd5);
		push_word(OP_LOOKUP, '1, 3'd0, 6'd0);
		push_word(OP_FREE, '0, 3'd0, 6'd1);
		push_word(OP_ALLOC, '1, 3'd1, 6'd0);

		// count above table size saturates
		set_slot_count(7'd127);
		push_word(OP_LOOKUP, '1, 3'd0, 6'd0);
		push_word(OP_FREE, '0, 3'd0, 6'd63);
		push_word(OP_ALLOC, key_pool[2], 3'd6, 6'd0);

		for (int p = 0; p < 10; p++) begin
			int alloc_pct;
			set_slot_count(CFG_W'(count_plan[p]));
			quiet = (p == 5);
			alloc_pct = $urandom_range(25, 50);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (p == 4 && n == PHASE_WORDS / 2)
					wait_for_replies();
				send_random_word(alloc_pct, count_plan[p]);
			end
		end
		quiet = 1'b0;

		wait_for_replies();
		repeat (80) @(posedge clk);
		$display("%0d words sent (alloc %0d, free %0d, lookup %0d, unused code %0d) over %0d slot counts",
			words_by_op[0] + words_by_op[1] + words_by_op[2] + words_by_op[3],
			words_by_op[0], words_by_op[1], words_by_op[2], words_by_op[3], settings_run);
		$display("%0d replies checked, %0d lookup hits, %0d allocations refused on a full table",
			checked, lookup_hits, alloc_full);
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
